@@ rtl/pli_pkg.sv @@
// Shared types, constants and knot table data for the piecewise-linear interpolation unit.
package pli_pkg;

    localparam int MAX_KNOTS   = 20;
    localparam int TABLE_COUNT = 4;

    localparam int ROM_TABLES  = 4;
    localparam int ROM_KNOTS   = 20;

    localparam int LIVE_TABLES = (TABLE_COUNT < ROM_TABLES) ? TABLE_COUNT : ROM_TABLES;

    localparam int SEL_W   = 2;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = $clog2(ROM_KNOTS + 1);
    localparam int TBL_W   = (ROM_TABLES > 1) ? $clog2(ROM_TABLES) : 1;
    localparam int KIDX_W  = (ROM_KNOTS > 1) ? $clog2(ROM_KNOTS) : 1;

    // serial multiplier: radix-4, two multiplier bits per cycle
    localparam int MUL_DIGIT = 2;
    localparam int MUL_STEPS = DATA_W / MUL_DIGIT;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

    // serial divider: restoring, one quotient bit per cycle
    localparam int DIV_STEPS = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // knot domain in units of dom_scale/1000, range in units of rng_scale*1e-7
    localparam int unsigned ROM_DOM [ROM_TABLES][ROM_KNOTS] = '{
        '{0, 1000, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 9000, 10000,
          15000, 20000, 25000, 30000, 40000, 50000, 60000, 70000, 80000},
        '{0, 1000, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 9000, 10000,
          15000, 20000, 25000, 30000, 40000, 50000, 60000, 70000, 80000},
        '{0, 1000, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 9000, 10000,
          15000, 20000, 25000, 30000, 40000, 50000, 60000, 70000, 80000},
        '{300, 500, 700, 890, 920, 960, 980, 1000, 1020, 1060, 1240, 1530,
          1990, 2870, 2890, 5000, 0, 0, 0, 0}
    };

    localparam int unsigned ROM_RNG [ROM_TABLES][ROM_KNOTS] = '{
        '{9807, 9804, 9801, 9797, 9794, 9791, 9788, 9785, 9782, 9779, 9776,
          9761, 9745, 9730, 9715, 9684, 9654, 9624, 9594, 9564},
        '{12250000, 11120000, 10070000, 9093000, 8194000, 7364000, 6601000,
          5900000, 5258000, 4671000, 4135000, 1948000, 889100, 400800, 184100,
          39960, 10270, 3097, 828, 185},
        '{340, 336, 332, 328, 324, 320, 316, 312, 308, 303, 299, 295, 295, 295,
          305, 324, 337, 319, 289, 269},
        '{1629, 1659, 2031, 2597, 3010, 3287, 4002, 4258, 4335, 4483, 4064,
          3663, 2897, 2297, 2306, 2656, 0, 0, 0, 0}
    };

    localparam int unsigned ROM_COUNT [ROM_TABLES] = '{20, 20, 20, 16};
    localparam longint unsigned DOM_SCALE [ROM_TABLES] = '{1000, 1000, 1000, 1};
    localparam longint unsigned RNG_SCALE [ROM_TABLES] = '{10000, 1, 10000000, 1000};

    typedef struct packed {
        logic [SEL_W-1:0]  table_select;
        logic [DATA_W-1:0] x_value;
    } pli_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] y_value;
        logic              out_of_range;
    } pli_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIV
    } pli_state_t;

    // elaboration-time conversions to Q20.12 / Q12.20, round half up
    function automatic longint unsigned knot_x(input int t, input int i);
        longint unsigned v;
        v = longint'(ROM_DOM[t][i]) * DOM_SCALE[t];
        return (v * 64'd4096 + 64'd500) / 64'd1000;
    endfunction

    function automatic longint unsigned knot_y(input int t, input int i);
        longint unsigned v;
        v = longint'(ROM_RNG[t][i]) * RNG_SCALE[t];
        return (v * 64'd1048576 + 64'd5000000) / 64'd10000000;
    endfunction

    function automatic int knot_count(input int t);
        int n;
        n = int'(ROM_COUNT[t]);
        if (n > MAX_KNOTS)
        begin
            n = MAX_KNOTS;
        end
        if (n > ROM_KNOTS)
        begin
            n = ROM_KNOTS;
        end
        return n;
    endfunction

endpackage

@@ rtl/pli_knot_rom.sv @@
// Constant knot tables: two adjacent knots of the selected table plus its knot count.
module pli_knot_rom (
    input  logic [pli_pkg::SEL_W-1:0]  sel,
    input  logic [pli_pkg::IDX_W-1:0]  idx,
    output logic [pli_pkg::DATA_W-1:0] kx0,
    output logic [pli_pkg::DATA_W-1:0] ky0,
    output logic [pli_pkg::DATA_W-1:0] kx1,
    output logic [pli_pkg::DATA_W-1:0] ky1,
    output logic [pli_pkg::IDX_W-1:0]  count
);

    logic [pli_pkg::DATA_W-1:0] x_tab [pli_pkg::ROM_TABLES][pli_pkg::ROM_KNOTS];
    logic [pli_pkg::DATA_W-1:0] y_tab [pli_pkg::ROM_TABLES][pli_pkg::ROM_KNOTS];
    logic [pli_pkg::IDX_W-1:0]  n_tab [pli_pkg::ROM_TABLES];

    logic [pli_pkg::IDX_W-1:0]  idx1;
    logic [pli_pkg::TBL_W-1:0]  t;

    for (genvar ti = 0; ti < pli_pkg::ROM_TABLES; ti++)
    begin : g_tbl
        localparam logic [pli_pkg::IDX_W-1:0] KN = pli_pkg::IDX_W'(pli_pkg::knot_count(ti));
        assign n_tab[ti] = KN;
        for (genvar ki = 0; ki < pli_pkg::ROM_KNOTS; ki++)
        begin : g_knot
            localparam logic [pli_pkg::DATA_W-1:0] KX =
                pli_pkg::DATA_W'(pli_pkg::knot_x(ti, ki));
            localparam logic [pli_pkg::DATA_W-1:0] KY =
                pli_pkg::DATA_W'(pli_pkg::knot_y(ti, ki));
            assign x_tab[ti][ki] = KX;
            assign y_tab[ti][ki] = KY;
        end
    end

    assign idx1 = idx + pli_pkg::IDX_W'(1);
    assign t    = pli_pkg::TBL_W'(sel);

    always_comb
    begin
        kx0   = '0;
        ky0   = '0;
        kx1   = '0;
        ky1   = '0;
        count = '0;
        if (32'(sel) < 32'(pli_pkg::ROM_TABLES))
        begin
            count = n_tab[t];
            if (32'(idx) < 32'(pli_pkg::ROM_KNOTS))
            begin
                kx0 = x_tab[t][idx[pli_pkg::KIDX_W-1:0]];
                ky0 = y_tab[t][idx[pli_pkg::KIDX_W-1:0]];
            end
            if (32'(idx1) < 32'(pli_pkg::ROM_KNOTS))
            begin
                kx1 = x_tab[t][idx1[pli_pkg::KIDX_W-1:0]];
                ky1 = y_tab[t][idx1[pli_pkg::KIDX_W-1:0]];
            end
        end
    end

endmodule

@@ rtl/pli_mul.sv @@
// Radix-4 shift-add multiplier: two multiplier bits per cycle, unsigned 32x32 to 64.
module pli_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pli_pkg::DATA_W-1:0]    a,
    input  logic [pli_pkg::DATA_W-1:0]    b,
    output logic                          done,
    output logic [2*pli_pkg::DATA_W-1:0]  product
);

    localparam int SUM_W = pli_pkg::DATA_W + pli_pkg::MUL_DIGIT;

    logic                          run_reg,  run_next;
    logic                          done_reg, done_next;
    logic [pli_pkg::MUL_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [pli_pkg::DATA_W-1:0]    hi_reg,   hi_next;
    logic [pli_pkg::DATA_W-1:0]    lo_reg,   lo_next;
    logic [pli_pkg::DATA_W-1:0]    b_reg,    b_next;
    logic [SUM_W-1:0]              sum;

    // partial product of the low digit, added to the running high half
    assign sum = SUM_W'(hi_reg)
               + SUM_W'(b_reg) * SUM_W'(lo_reg[pli_pkg::MUL_DIGIT-1:0]);

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        b_next    = b_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            hi_next  = '0;
            lo_next  = a;
            b_next   = b;
        end
        else if (run_reg)
        begin
            hi_next  = sum[SUM_W-1:pli_pkg::MUL_DIGIT];
            lo_next  = {sum[pli_pkg::MUL_DIGIT-1:0],
                        lo_reg[pli_pkg::DATA_W-1:pli_pkg::MUL_DIGIT]};
            cnt_next = cnt_reg + pli_pkg::MUL_CNT_W'(1);
            if (cnt_reg == pli_pkg::MUL_CNT_W'(pli_pkg::MUL_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        b_reg  <= b_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

@@ rtl/pli_div.sv @@
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// The high half of the dividend must already be below the divisor.
module pli_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [2*pli_pkg::DATA_W-1:0]  dividend,
    input  logic [pli_pkg::DATA_W-1:0]    divisor,
    output logic                          done,
    output logic [pli_pkg::DATA_W-1:0]    quotient
);

    localparam int REM_W = pli_pkg::DATA_W + 1;

    logic                          run_reg,  run_next;
    logic                          done_reg, done_next;
    logic [pli_pkg::DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [pli_pkg::DATA_W-1:0]    rem_reg,  rem_next;
    logic [pli_pkg::DATA_W-1:0]    q_reg,    q_next;
    logic [pli_pkg::DATA_W-1:0]    dv_reg,   dv_next;
    logic [REM_W-1:0]              trial;
    logic [REM_W-1:0]              diff;
    logic                          fits;

    assign trial = {rem_reg, q_reg[pli_pkg::DATA_W-1]};
    assign diff  = trial - {1'b0, dv_reg};
    assign fits  = (trial >= {1'b0, dv_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dv_next   = dv_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = dividend[2*pli_pkg::DATA_W-1:pli_pkg::DATA_W];
            q_next   = dividend[pli_pkg::DATA_W-1:0];
            dv_next  = divisor;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[pli_pkg::DATA_W-1:0] : trial[pli_pkg::DATA_W-1:0];
            q_next   = {q_reg[pli_pkg::DATA_W-2:0], fits};
            cnt_next = cnt_reg + pli_pkg::DIV_CNT_W'(1);
            if (cnt_reg == pli_pkg::DIV_CNT_W'(pli_pkg::DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dv_reg  <= dv_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ rtl/piecewise_linear_table_interp_unit.sv @@
// Top level of the piecewise-linear table interpolation unit.
//
// One lookup per transaction: start is taken while busy is low, together with a
// table selector (0 gravity, 1 air density, 2 speed of sound, all by altitude;
// 3 drag coefficient by Mach) and an unsigned Q20.12 argument. The result, an
// unsigned Q12.20 value plus an out-of-range flag, shows on result for exactly
// one cycle with done high; there is no backpressure, so the receiver must
// capture it in that cycle. busy drops in the same cycle that done rises, so a
// new transaction may start right then. The knot scan checks one segment per
// cycle, up to 19 for the altitude tables; a hit then runs the radix-4 serial
// multiplier and after it the bit-serial divider. A lookup that lands outside
// the table finishes right after the scan, and a segment whose two knots
// coincide returns its lower knot value right after the scan.
// An argument on a shared knot uses the lower segment.
module piecewise_linear_table_interp_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pli_pkg::pli_req_t  request,
    output logic               done,
    output pli_pkg::pli_rsp_t  result
);

    localparam int W   = pli_pkg::DATA_W;
    localparam int SUM_W = W + 1;

    pli_pkg::pli_state_t state_reg, state_next;

    logic [pli_pkg::SEL_W-1:0] sel_reg, sel_next;
    logic [W-1:0]              x_reg,   x_next;
    logic [pli_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [W-1:0]              dd_reg,  dd_next;   // segment width d1 - d0
    logic [W-1:0]              r0_reg,  r0_next;
    logic                      neg_reg, neg_next;  // slope is negative
    pli_pkg::pli_rsp_t         rsp_reg, rsp_next;
    logic                      done_reg, done_next;

    // knot ROM
    logic [W-1:0]              kx0, ky0, kx1, ky1;
    logic [pli_pkg::IDX_W-1:0] kcount;

    // FSM outputs
    logic accept;
    logic scan_end;    // no segment left
    logic scan_hit;    // argument inside current segment
    logic mul_start;
    logic div_start;

    logic                  mul_done;
    logic [2*W-1:0]        mul_prod;
    logic [W-1:0]          mul_a, mul_b;
    logic                  div_done;
    logic [W-1:0]          div_q;

    logic [SUM_W-1:0]      y_up;
    logic [W-1:0]          y_final;
    logic                  sel_live;

    pli_knot_rom u_rom (
        .sel   (sel_reg),
        .idx   (idx_reg),
        .kx0   (kx0),
        .ky0   (ky0),
        .kx1   (kx1),
        .ky1   (ky1),
        .count (kcount)
    );

    pli_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_prod),
        .divisor  (dd_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign accept   = start && (state_reg == pli_pkg::ST_IDLE);
    assign sel_live = 32'(request.table_select) < 32'(pli_pkg::LIVE_TABLES);

    // segment test: stop once idx+1 reaches the knot count
    assign scan_end = !(32'(idx_reg) + 32'd1 < 32'(kcount));
    assign scan_hit = (x_reg >= kx0) && (x_reg <= kx1);

    // multiplier operands: |x - d0| and |r1 - r0|
    assign mul_a = x_reg - kx0;
    assign mul_b = (ky1 < ky0) ? (ky0 - ky1) : (ky1 - ky0);

    // r0 +/- q, clamped to the unsigned 32-bit range
    assign y_up = {1'b0, r0_reg} + {1'b0, div_q};
    always_comb
    begin
        if (neg_reg)
        begin
            y_final = (div_q > r0_reg) ? '0 : (r0_reg - div_q);
        end
        else
        begin
            y_final = y_up[W] ? {W{1'b1}} : y_up[W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pli_pkg::ST_IDLE:
            begin
                if (start && sel_live)
                begin
                    state_next = pli_pkg::ST_SCAN;
                end
            end
            pli_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = pli_pkg::ST_IDLE;
                end
                else if (scan_hit)
                begin
                    state_next = (kx1 == kx0) ? pli_pkg::ST_IDLE : pli_pkg::ST_MUL;
                end
            end
            pli_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = pli_pkg::ST_DIV;
                end
            end
            pli_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = pli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pli_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        mul_start = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            pli_pkg::ST_SCAN:
            begin
                mul_start = !scan_end && scan_hit && (kx1 != kx0);
            end
            pli_pkg::ST_MUL:
            begin
                div_start = mul_done;
            end
            pli_pkg::ST_IDLE, pli_pkg::ST_DIV:
            begin
                mul_start = 1'b0;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        sel_next  = sel_reg;
        x_next    = x_reg;
        idx_next  = idx_reg;
        dd_next   = dd_reg;
        r0_next   = r0_reg;
        neg_next  = neg_reg;
        rsp_next  = rsp_reg;
        done_next = 1'b0;

        if (accept)
        begin
            sel_next = request.table_select;
            x_next   = request.x_value;
            idx_next = '0;
            if (!sel_live)
            begin
                rsp_next.y_value      = '0;
                rsp_next.out_of_range = 1'b1;
                done_next             = 1'b1;
            end
        end

        if (state_reg == pli_pkg::ST_SCAN)
        begin
            if (scan_end)
            begin
                rsp_next.y_value      = '0;
                rsp_next.out_of_range = 1'b1;
                done_next             = 1'b1;
            end
            else if (scan_hit)
            begin
                dd_next  = kx1 - kx0;
                r0_next  = ky0;
                neg_next = ky1 < ky0;
                if (kx1 == kx0)
                begin
                    rsp_next.y_value      = ky0;
                    rsp_next.out_of_range = 1'b0;
                    done_next             = 1'b1;
                end
            end
            else
            begin
                idx_next = idx_reg + pli_pkg::IDX_W'(1);
            end
        end

        if ((state_reg == pli_pkg::ST_DIV) && div_done)
        begin
            rsp_next.y_value      = y_final;
            rsp_next.out_of_range = 1'b0;
            done_next             = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pli_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        x_reg   <= x_next;
        dd_reg  <= dd_next;
        r0_reg  <= r0_next;
        neg_reg <= neg_next;
        rsp_reg <= rsp_next;
    end

    assign busy   = (state_reg != pli_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule
